// ----- rtl/ffcf_pkg.sv -----
// Package for the fractional feedback comb filter: default sizes, register
// indexes, sequencer states and the control bundle for the arithmetic unit.
// No dependencies.
package ffcf_pkg;

	localparam int STORE_DEPTH_DEF  = 4096;
	localparam int SAMPLE_WIDTH_DEF = 16;

	localparam int WHOLE_W = 12;
	localparam int FRAC_W  = 16;
	localparam int GAIN_W  = 15;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 2;

	localparam logic [CIDX_W-1:0] REG_DELAY_WHOLE    = 2'd0;
	localparam logic [CIDX_W-1:0] REG_DELAY_FRACTION = 2'd1;
	localparam logic [CIDX_W-1:0] REG_FEEDBACK_GAIN  = 2'd2;

	localparam logic [WHOLE_W-1:0] DELAY_WHOLE_RST = 12'd48;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD2,
		ST_MIX,
		ST_FBK,
		ST_WR
	} state_t;

	typedef struct packed {
		logic ld_t1;
		logic ld_prod;
		logic ld_fb;
	} mix_ctl_t;

endpackage

// ----- rtl/ffcf_store.sv -----
// Delay store: synchronous RAM with one write port and one read port,
// read data registered. Depends on nothing.
module ffcf_store #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/ffcf_mix.sv -----
// Tap interpolation, feedback scaling and saturating sums of the comb filter.
// Depends on ffcf_pkg.
module ffcf_mix #(
	parameter int SW = ffcf_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  ffcf_pkg::mix_ctl_t            ctl,
	input  logic signed [SW-1:0]          tap,
	input  logic signed [SW-1:0]          x,
	input  logic [ffcf_pkg::FRAC_W-1:0]   frac,
	input  logic [ffcf_pkg::GAIN_W-1:0]   gain,
	output logic signed [SW-1:0]          store_val,
	output logic signed [SW-1:0]          y
);

	localparam int PW = SW + 18;

	logic signed [SW-1:0] t1_q;
	logic signed [PW-1:0] prod_q;
	logic signed [SW+1:0] delayed_q;
	logic signed [PW-1:0] fbp_q;

	logic signed [SW:0]   diff;
	logic signed [PW-1:0] prod_c;
	logic signed [PW-1:0] prod_r;
	logic signed [SW+1:0] delayed_c;
	logic signed [PW-1:0] fbp_c;
	logic signed [PW-1:0] fbp_r;
	logic signed [SW+3:0] sum_fb;
	logic signed [SW+3:0] sum_out;

	localparam logic signed [SW+3:0] SMAX = (SW+4)'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [SW+3:0] SMIN = -SMAX - (SW+4)'(1);

	assign diff   = (SW+1)'(tap) - (SW+1)'(t1_q);
	assign prod_c = PW'(diff) * PW'($signed({1'b0, frac}));
	assign prod_r = prod_q + PW'(32768);
	assign delayed_c = (SW+2)'(t1_q) + prod_r[SW+17:16];
	assign fbp_c  = PW'(delayed_c) * PW'($signed({1'b0, gain}));
	assign fbp_r  = fbp_q + PW'(16384);

	assign sum_fb  = (SW+4)'(x) + (SW+4)'($signed(fbp_r[SW+17:15]));
	assign sum_out = (SW+4)'(x) + (SW+4)'(delayed_q);

	always_comb begin
		if (sum_fb > SMAX) begin
			store_val = SMAX[SW-1:0];
		end else if (sum_fb < SMIN) begin
			store_val = SMIN[SW-1:0];
		end else begin
			store_val = sum_fb[SW-1:0];
		end
		if (sum_out > SMAX) begin
			y = SMAX[SW-1:0];
		end else if (sum_out < SMIN) begin
			y = SMIN[SW-1:0];
		end else begin
			y = sum_out[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_t1) begin
			t1_q <= tap;
		end
		if (ctl.ld_prod) begin
			prod_q <= prod_c;
		end
		if (ctl.ld_fb) begin
			delayed_q <= delayed_c;
			fbp_q     <= fbp_c;
		end
	end

endmodule

// ----- rtl/fractional_feedback_comb_filter.sv -----
// Fractional feedback comb filter, top level: sequencer, registers, pointer.
// Beats step IDLE, RD2, MIX, FBK, WR; WR waits on out_ready, writes the store and loads
// the output; no new beat is taken till WR ends. Limits: one store read port (two tap
// reads) and two registered multiplies. Uses ffcf_pkg, ffcf_store, ffcf_mix.
// Reset clears control state, fraction and gain, sets delay whole to 48; store entries
// not yet written read as zero via write pointer and wrap flag (no clearing pass).
module fractional_feedback_comb_filter #(
	parameter int STORE_DEPTH  = ffcf_pkg::STORE_DEPTH_DEF,
	parameter int SAMPLE_WIDTH = ffcf_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ffcf_pkg::CIDX_W-1:0]      cfg_index,
	input  logic [ffcf_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]   sample_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]   sample_out
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = (AW > ffcf_pkg::WHOLE_W) ? AW : ffcf_pkg::WHOLE_W;
	localparam logic [CW-1:0] DMAX = CW'(STORE_DEPTH - 1);
	localparam logic [AW-1:0] LAST = AW'(STORE_DEPTH - 1);

	ffcf_pkg::state_t   state_q, state_d;
	ffcf_pkg::mix_ctl_t ctl;

	logic [ffcf_pkg::WHOLE_W-1:0] delay_whole_q;
	logic [ffcf_pkg::FRAC_W-1:0]  delay_fraction_q;
	logic [ffcf_pkg::GAIN_W-1:0]  feedback_gain_q;

	logic [AW-1:0] wp_q;
	logic          wrapped_q;
	logic [AW-1:0] r2_q;
	logic          v1_q, v2_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic          out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;

	logic [CW-1:0]  d_ext, d_cl;
	logic [AW-1:0]  d_a;
	logic [AW:0]    r1_w;
	logic [AW-1:0]  r1_c, r2_c;
	logic           v1_c, v2_c;
	logic           accept, we, out_ld;
	logic [AW-1:0]  raddr;
	logic [SAMPLE_WIDTH-1:0] rdata;
	logic signed [SAMPLE_WIDTH-1:0] tap;
	logic signed [SAMPLE_WIDTH-1:0] store_val, y;

	assign d_ext = CW'(delay_whole_q);
	always_comb begin
		if (d_ext == '0) begin
			d_cl = CW'(1);
		end else if (d_ext > DMAX) begin
			d_cl = DMAX;
		end else begin
			d_cl = d_ext;
		end
	end
	assign d_a  = d_cl[AW-1:0];
	assign r1_w = {1'b0, wp_q} - {1'b0, d_a};
	assign r1_c = r1_w[AW] ? AW'(r1_w + (AW+1)'(STORE_DEPTH)) : r1_w[AW-1:0];
	assign r2_c = (r1_c == '0) ? LAST : r1_c - AW'(1);
	assign v1_c = wrapped_q | (r1_c < wp_q);
	assign v2_c = wrapped_q | (r2_c < wp_q);

	assign in_ready = (state_q == ffcf_pkg::ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign raddr    = (state_q == ffcf_pkg::ST_IDLE) ? r1_c : r2_q;
	assign tap      = ((state_q == ffcf_pkg::ST_RD2) ? v1_q : v2_q) ? $signed(rdata) : '0;

	always_comb begin
		state_d     = state_q;
		ctl         = '0;
		we          = 1'b0;
		out_ld      = 1'b0;
		case (state_q)
			ffcf_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = ffcf_pkg::ST_RD2;
				end
			end
			ffcf_pkg::ST_RD2: begin
				ctl.ld_t1 = 1'b1;
				state_d   = ffcf_pkg::ST_MIX;
			end
			ffcf_pkg::ST_MIX: begin
				ctl.ld_prod = 1'b1;
				state_d     = ffcf_pkg::ST_FBK;
			end
			ffcf_pkg::ST_FBK: begin
				ctl.ld_fb = 1'b1;
				state_d   = ffcf_pkg::ST_WR;
			end
			ffcf_pkg::ST_WR: begin
				if (!out_valid_q || out_ready) begin
					we      = 1'b1;
					out_ld  = 1'b1;
					state_d = ffcf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ffcf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffcf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_whole_q    <= ffcf_pkg::DELAY_WHOLE_RST;
			delay_fraction_q <= '0;
			feedback_gain_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ffcf_pkg::REG_DELAY_WHOLE:    delay_whole_q    <= cfg_data[ffcf_pkg::WHOLE_W-1:0];
				ffcf_pkg::REG_DELAY_FRACTION: delay_fraction_q <= cfg_data[ffcf_pkg::FRAC_W-1:0];
				ffcf_pkg::REG_FEEDBACK_GAIN:  feedback_gain_q  <= cfg_data[ffcf_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (we) begin
				if (wp_q == LAST) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + AW'(1);
				end
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q  <= sample_in;
			r2_q <= r2_c;
			v1_q <= v1_c;
			v2_q <= v2_c;
		end
		if (out_ld) begin
			sample_out_q <= y;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	ffcf_store #(
		.DEPTH(STORE_DEPTH),
		.WIDTH(SAMPLE_WIDTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(wp_q),
		.wdata(store_val),
		.raddr(raddr),
		.rdata(rdata)
	);

	ffcf_mix #(
		.SW(SAMPLE_WIDTH)
	) u_mix (
		.clk      (clk),
		.ctl      (ctl),
		.tap      (tap),
		.x        (x_q),
		.frac     (delay_fraction_q),
		.gain     (feedback_gain_q),
		.store_val(store_val),
		.y        (y)
	);

	a_pointer_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!we |=> $stable(wp_q))
		else $error("write pointer moved without a store write");

	a_item_reaches_write: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 state_q == ffcf_pkg::ST_WR)
		else $error("accepted beat did not reach the write step");

	a_wrap_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wrapped_q |=> wrapped_q)
		else $error("wrap flag cleared outside reset");

endmodule
